### rtl/sha1_message_digest_top_assert.svh
`ifndef SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SHA1_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA1_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/sha1md_pkg.sv
package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  typedef struct packed {
    logic load;
    logic start;
    logic init;
  } core_ctl_t;

  localparam int ROUNDS = 80;

  localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                           32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

### rtl/sha1md_core.sv
module sha1md_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1md_pkg::core_ctl_t ctl,
  input  sha1md_pkg::word_t     load_word,
  output logic                 busy,
  output sha1md_pkg::chain_t    chain
);

  sha1md_pkg::chain_t chain_r;
  sha1md_pkg::word_t  window_r [16];
  sha1md_pkg::word_t  work_r [5];
  logic [6:0]         rnd_r;
  logic               busy_r;
  logic               fin_r;

  sha1md_pkg::word_t f;
  sha1md_pkg::word_t k;
  sha1md_pkg::word_t temp;
  sha1md_pkg::word_t w_mix;
  sha1md_pkg::word_t w_new;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      k = sha1md_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
      k = sha1md_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) | (work_r[2] & work_r[3]);
      k = sha1md_pkg::K2;
    end else begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
      k = sha1md_pkg::K3;
    end
    temp  = {work_r[0][26:0], work_r[0][31:27]} + f + work_r[4] + k + window_r[0];
    w_mix = window_r[13] ^ window_r[8] ^ window_r[2] ^ window_r[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  // schedule window: shift line, new words enter at the top
  always_ff @(posedge clk) begin
    if (ctl.load || busy_r) begin
      for (int i = 0; i < 15; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[15] <= ctl.load ? load_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 5; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (busy_r) begin
      work_r[0] <= temp;
      work_r[1] <= work_r[0];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha1md_pkg::IV;
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      rnd_r   <= '0;
    end else begin
      if (ctl.init) begin
        chain_r <= sha1md_pkg::IV;
      end else if (fin_r) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
      end
      fin_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        if (rnd_r == 7'(sha1md_pkg::ROUNDS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
          rnd_r  <= '0;
        end else begin
          rnd_r <= rnd_r + 7'd1;
        end
      end
    end
  end

  assign busy  = busy_r | fin_r;
  assign chain = chain_r;

endmodule

### rtl/sha1_message_digest_top.sv
// Byte item: taken while in_stall is low; a byte that completes a 64-byte block starts
// a compression (80 rounds of the shared round unit, one chaining add, handoff).
// End item: one pad byte per cycle up to the length field, then the two length words,
// one or two compressions, then five digest items, one per cycle when out_stall is low.
// The input stalls while a block compresses; no byte is taken until the core is done.
// Synchronous active-low reset: chaining words to the SHA-1 IV, count and control cleared.
`include "sha1_message_digest_top_assert.svh"

module sha1_message_digest_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ret_r, ret_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] count_r, count_nxt;
  logic [23:0] pack_r, pack_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_sel_r, len_sel_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  idx_r, idx_nxt;

  sha1md_pkg::core_ctl_t ctl;
  sha1md_pkg::word_t     load_word;
  sha1md_pkg::chain_t    chain;
  logic                  core_busy;
  logic                  in_acc;
  logic                  out_acc;
  logic [7:0]            byte_sel;
  logic [63:0]           bit_len;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid_r & ~out_stall;
  assign bit_len  = {count_r[60:0], 3'b000};

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    pack_nxt      = pack_r;
    pad_first_nxt = pad_first_r;
    len_sel_nxt   = len_sel_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    ctl           = '0;
    byte_sel      = (state_r == S_PAD) ? (pad_first_r ? sha1md_pkg::PAD_BYTE : 8'h00)
                                       : in_message_byte;
    load_word     = (state_r == S_LEN) ? (len_sel_r ? bit_len[31:0] : bit_len[63:32])
                                       : {pack_r, byte_sel};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pad_first_nxt = 1'b1;
          if (in_byte_present) begin
            pack_nxt  = {pack_r[15:0], byte_sel};
            ctl.load  = (pos_r[1:0] == 2'd3);
            pos_nxt   = pos_r + 6'd1;
            count_nxt = count_r + 64'd1;
          end
          if (in_byte_present && pos_r == 6'd63) begin
            ctl.start = 1'b1;
            state_nxt = S_COMP;
            ret_nxt   = in_end_of_message ? S_PAD : S_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        pack_nxt      = {pack_r[15:0], byte_sel};
        ctl.load      = (pos_r[1:0] == 2'd3);
        pos_nxt       = pos_r + 6'd1;
        pad_first_nxt = 1'b0;
        if (pos_r == 6'd63) begin
          ctl.start = 1'b1;
          state_nxt = S_COMP;
          ret_nxt   = S_PAD;
        end else if (pos_r == 6'd55) begin
          state_nxt   = S_LEN;
          len_sel_nxt = 1'b0;
        end
      end
      S_LEN: begin
        ctl.load    = 1'b1;
        len_sel_nxt = 1'b1;
        if (len_sel_r) begin
          ctl.start = 1'b1;
          state_nxt = S_COMP;
          ret_nxt   = S_OUT;
        end
      end
      S_COMP: begin
        if (!core_busy) begin
          state_nxt = ret_r;
          if (ret_r == S_OUT) begin
            out_valid_nxt = 1'b1;
            idx_nxt       = '0;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (idx_r == 3'd4) begin
            out_valid_nxt = 1'b0;
            ctl.init      = 1'b1;
            count_nxt     = '0;
            pos_nxt       = '0;
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      pos_r       <= '0;
      count_r     <= '0;
      pad_first_r <= 1'b0;
      len_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      pad_first_r <= pad_first_nxt;
      len_sel_r   <= len_sel_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pack_r <= pack_nxt;
  end

  sha1md_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_word (load_word),
    .busy      (core_busy),
    .chain     (chain)
  );

  always_comb begin
    case (idx_r)
      3'd0:    out_digest_word = chain[0];
      3'd1:    out_digest_word = chain[1];
      3'd2:    out_digest_word = chain[2];
      3'd3:    out_digest_word = chain[3];
      3'd4:    out_digest_word = chain[4];
      default: out_digest_word = chain[0];
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_word_number = idx_r;
  assign out_last_word   = (idx_r == 3'd4);

  `SHA1_ASSERT_IMPL(a_out_in_state, clk, rst_n, out_valid_r, state_r == S_OUT, "item out of state")
  `SHA1_ASSERT_IMPL(a_idle_core, clk, rst_n, !in_stall, !core_busy, "ready while core busy")
  `SHA1_ASSERT_IMPL(a_start_idle, clk, rst_n, ctl.start, !core_busy, "start while core busy")
  `SHA1_ASSERT_NEXT(a_len_comp, clk, rst_n, state_r == S_LEN && len_sel_r, state_r == S_COMP, "no compress after length")
  `SHA1_ASSERT_NEXT(a_last_clear, clk, rst_n, out_acc && idx_r == 3'd4, state_r == S_IDLE && count_r == 64'd0, "no clear after digest")

endmodule

### dv/sha1_message_digest_top_tb.sv
`timescale 1ns / 1ps

module sha1_message_digest_top_tb;

  typedef struct {
    sha1md_pkg::word_t word;
    logic [2:0]        number;
    logic              last;
  } digest_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_message_byte = 8'h00;
  logic       in_byte_present = 1'b0;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_last_word;

  sha1md_pkg::word_t sha_chain[5];
  sha1md_pkg::word_t sha_window[16];
  logic [63:0]       sha_byte_count;
  digest_word_t      digest_q[$];

  int   errors = 0;
  int   msg_items = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  logic holding = 1'b0;
  event hold_ev;

  sha1_message_digest_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_message_byte  (in_message_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_word_number  (out_word_number),
    .out_last_word    (out_last_word)
  );

  always #5 clk = ~clk;

  // SHA-1 predictor
  function automatic void sha_restart();
    for (int i = 0; i < 5; i++) sha_chain[i] = sha1md_pkg::IV[i];
    for (int i = 0; i < 16; i++) sha_window[i] = '0;
    sha_byte_count = '0;
  endfunction

  function automatic void sha_put_byte(int pos, logic [7:0] b);
    int wi;
    wi = (pos >> 2) & 15;
    if ((pos & 3) == 0) sha_window[wi] = '0;
    sha_window[wi][(3 - (pos & 3)) * 8 +: 8] = b;
  endfunction

  function automatic void sha_compress();
    sha1md_pkg::word_t w[16];
    sha1md_pkg::word_t a, b, c, d, e, f, k, wt, sum;
    for (int i = 0; i < 16; i++) w[i] = sha_window[i];
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int t = 0; t < sha1md_pkg::ROUNDS; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15];
        wt = {wt[30:0], wt[31]};
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endfunction

  function automatic void sha_absorb(logic [7:0] b, logic present, logic eom);
    int pos;
    logic [63:0] bits;
    digest_word_t dw;
    if (present) begin
      pos = int'(sha_byte_count[5:0]);
      sha_put_byte(pos, b);
      sha_byte_count++;
      if (pos == 63) sha_compress();
    end
    if (!eom) return;
    bits = sha_byte_count << 3;
    pos = int'(sha_byte_count[5:0]);
    sha_put_byte(pos, sha1md_pkg::PAD_BYTE);
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        sha_put_byte(pos, 8'h00);
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < 56) begin
      sha_put_byte(pos, 8'h00);
      pos++;
    end
    sha_window[14] = bits[63:32];
    sha_window[15] = bits[31:0];
    sha_compress();
    for (int i = 0; i < 5; i++) begin
      dw.word = sha_chain[i];
      dw.number = 3'(i);
      dw.last = (i == 4);
      digest_q.push_back(dw);
    end
    sha_restart();
  endfunction

  // receiver: random stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holding) begin
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ~out_stall;
      endcase
    end
    if ($urandom_range(0, 47) == 0) stall_mode <= $urandom_range(0, 3);
  end

  initial begin
    forever begin
      @(hold_ev);
      holding <= 1'b1;
      repeat (400) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // digest checker
  always @(posedge clk) begin
    digest_word_t dw;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item word %h number %0d last %0b",
                 $time, out_digest_word, out_word_number, out_last_word);
        errors++;
      end else begin
        dw = digest_q.pop_front();
        if (out_digest_word !== dw.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, dw.word,
                   out_digest_word);
          errors++;
        end
        if (out_word_number !== dw.number) begin
          $display("%0t: word_number expected %0d actual %0d", $time, dw.number,
                   out_word_number);
          errors++;
        end
        if (out_last_word !== dw.last) begin
          $display("%0t: last_word expected %0b actual %0b", $time, dw.last,
                   out_last_word);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_message_byte <= b;
    in_byte_present <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    sha_absorb(b, present, eom);
    if (present || eom) msg_items++;
  endtask

  task automatic send_message(input int len, input bit end_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1));
    end
    if (!end_with_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_empty_items();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
  endtask

  task automatic test_empty_message();
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(sha1md_pkg::PAD_BYTE, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b1);
  endtask

  task automatic test_abc();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // lengths around the pad/length split and a full block
  task automatic test_block_boundaries();
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(64, 1'b1);
  endtask

  task automatic test_output_backpressure();
    -> hold_ev;
    for (int i = 0; i < 4; i++) send_message($urandom_range(0, 4), $urandom_range(0, 1));
  endtask

  task automatic test_random_messages();
    int len;
    int pick;
    while (msg_items < 410) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 20);
      else if (pick < 8) len = $urandom_range(52, 70);
      else if (pick == 8) len = $urandom_range(110, 135);
      else len = $urandom_range(0, 3);
      send_message(len, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int waited;
    sha_restart();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_items();
    test_empty_message();
    test_byte_extremes();
    test_abc();
    test_block_boundaries();
    test_output_backpressure();
    test_random_messages();
    in_valid <= 1'b0;
    waited = 0;
    while (digest_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (digest_q.size() != 0) begin
      $display("%0t: %0d digest items never arrived", $time, digest_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("sha1_message_digest_top_tb: done, clean");
    end else begin
      $display("sha1_message_digest_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("sha1_message_digest_top_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest_top.sv
dv/sha1_message_digest_top_tb.sv
